[hw/rtl/svf_pkg.sv]
`default_nettype none

package svf_pkg;

  // Store geometry: the packed cell index addresses the store modulo its depth
  localparam int IDX_W      = 15;
  localparam int MAT_W      = 8;
  localparam int SIZE_W     = 6;
  localparam int PLANE_W    = 2 * SIZE_W;
  localparam int VOL_W      = 3 * SIZE_W;
  localparam int STORE_CELLS = 1 << IDX_W;
  // Compare width for cursors against extents (cursor never exceeds 64)
  localparam int CMP_W      = 8;
  // Command queue between front and back
  localparam int Q_DEPTH    = 2;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NEXT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // Neighbor visiting order: +y, -y, +x, -x, -z, +z
  typedef enum logic [2:0] {
    NB_YP = 3'd0,
    NB_YN = 3'd1,
    NB_XP = 3'd2,
    NB_XN = 3'd3,
    NB_ZN = 3'd4,
    NB_ZP = 3'd5
  } nb_dir_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] cell_index;
    logic [MAT_W-1:0] material;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic             found;
  } out_beat_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] cell_index;
    logic [MAT_W-1:0] material;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  sx;
    logic [SIZE_W-1:0]  sy;
    logic [SIZE_W-1:0]  sz;
    logic [PLANE_W-1:0] plane;
    logic [VOL_W-1:0]   volume;
  } geom_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

[hw/rtl/svf_in_if.sv]
`default_nettype none

interface svf_in_if;
  logic               valid;
  logic               ready;
  svf_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/svf_out_if.sv]
`default_nettype none

interface svf_out_if;
  logic               valid;
  logic               ready;
  svf_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/svf_front.sv]
`default_nettype none

module svf_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  svf_in_if.sink                     in_ch,
  input  wire svf_pkg::back_status_t status,
  input  wire logic                  q_full,
  output svf_pkg::cmd_t              push_cmd,
  output logic                       push
);

  logic          stg_valid;
  svf_pkg::cmd_t stg;
  logic          take;

  // Hold off beats while the store is swept after reset
  assign in_ch.ready = !status.init_busy && (!stg_valid || !q_full);
  assign take        = in_ch.valid && in_ch.ready;

  assign push     = stg_valid && !q_full;
  assign push_cmd = stg;

  // Stage register: decode the opcode into a command
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (take) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg.op         <= svf_pkg::op_t'(in_ch.data.opcode);
      stg.cell_index <= in_ch.data.cell_index;
      stg.material   <= in_ch.data.material;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/svf_queue.sv]
`default_nettype none

module svf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire svf_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output svf_pkg::cmd_t      head,
  output logic               full,
  output logic               empty
);

  localparam int PW = (svf_pkg::Q_DEPTH > 1) ? $clog2(svf_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(svf_pkg::Q_DEPTH + 1);

  svf_pkg::cmd_t entries [svf_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(svf_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(svf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(svf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/svf_back.sv]
`default_nettype none

module svf_back #(
  parameter int MAX_AXIS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire svf_pkg::geom_t geom,
  input  wire svf_pkg::cmd_t  head,
  input  wire logic           q_empty,
  output logic                pop,
  output svf_pkg::back_status_t status,
  svf_out_if.source           out_ch
);

  localparam int EXT_MAX = (MAX_AXIS < 63) ? MAX_AXIS : 63;
  localparam int CW      = $clog2(EXT_MAX + 2);
  localparam int IW      = svf_pkg::IDX_W;
  localparam int CMPW    = svf_pkg::CMP_W;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_WRITE = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_ADDR  = 10'b0000100000,
    S_CHK   = 10'b0001000000,
    S_NB    = 10'b0010000000,
    S_NBW   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic   init_done;

  // Voxel store, single write port and one registered read port
  logic [svf_pkg::MAT_W-1:0] mem [svf_pkg::STORE_CELLS];
  logic [svf_pkg::MAT_W-1:0] rd_data;
  logic [IW-1:0]             rd_addr;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic [svf_pkg::MAT_W-1:0] mem_wdata;
  logic [IW-1:0]             clr_cnt;

  svf_pkg::cmd_t cmd;

  // Scan position and the cell under test
  logic [CW-1:0] cur_x, cur_y, cur_z;
  logic          finished;
  logic [CW-1:0] cx, cy, cz;
  logic [IW-1:0] prod_y, prod_z;
  logic [IW-1:0] center;
  logic [IW-1:0] center_sum;
  svf_pkg::nb_dir_t nb;
  logic          nb_out;
  logic [IW-1:0] nb_addr;

  logic [IW-1:0] res_index;
  logic          res_found;

  logic                 out_valid;
  svf_pkg::out_beat_t   out_data;
  logic                 out_load;

  logic [CMPW-1:0] ex, ey, ez;
  logic            empty_grid;

  assign status.init_busy = !init_done;
  assign pop              = (state == S_IDLE) && !q_empty;
  assign out_ch.valid     = out_valid;
  assign out_ch.data      = out_data;
  assign out_load         = (state == S_OUT) && (!out_valid || out_ch.ready);

  assign ex         = CMPW'(geom.sx);
  assign ey         = CMPW'(geom.sy);
  assign ez         = CMPW'(geom.sz);
  assign empty_grid = (geom.sx == '0) || (geom.sy == '0) || (geom.sz == '0);
  assign center_sum = IW'(cx) + prod_y + prod_z;

  // Neighbor bounds and address, offsets applied to the packed center index
  always_comb begin
    nb_out  = 1'b1;
    nb_addr = center;
    case (nb)
      svf_pkg::NB_YP: begin
        nb_out  = (CMPW'(cy) + 1'b1) >= ey;
        nb_addr = center + IW'(geom.sx);
      end
      svf_pkg::NB_YN: begin
        nb_out  = (cy == '0);
        nb_addr = center - IW'(geom.sx);
      end
      svf_pkg::NB_XP: begin
        nb_out  = (CMPW'(cx) + 1'b1) >= ex;
        nb_addr = center + 1'b1;
      end
      svf_pkg::NB_XN: begin
        nb_out  = (cx == '0);
        nb_addr = center - 1'b1;
      end
      svf_pkg::NB_ZN: begin
        nb_out  = (cz == '0);
        nb_addr = center - IW'(geom.plane);
      end
      svf_pkg::NB_ZP: begin
        nb_out  = (CMPW'(cz) + 1'b1) >= ez;
        nb_addr = center + IW'(geom.plane);
      end
      default: begin
        nb_out  = 1'b1;
        nb_addr = center;
      end
    endcase
  end

  // Read address select
  always_comb begin
    case (state)
      S_ADDR:  rd_addr = center_sum;
      S_NB:    rd_addr = nb_addr;
      default: rd_addr = center;
    endcase
  end

  // Write port: sweep or single cell write inside the grid
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WRITE: begin
        mem_we    = svf_pkg::VOL_W'(cmd.cell_index) < geom.volume;
        mem_waddr = cmd.cell_index;
        mem_wdata = cmd.material;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init_done <= 1'b0;
      clr_cnt   <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_z     <= '0;
      finished  <= 1'b0;
      nb        <= svf_pkg::NB_YP;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            init_done <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            case (head.op)
              svf_pkg::OP_WRITE:   state <= S_WRITE;
              svf_pkg::OP_CLEAR:   state <= S_CLEAR;
              svf_pkg::OP_RESTART: begin
                cur_x    <= '0;
                cur_y    <= '0;
                cur_z    <= '0;
                finished <= 1'b0;
              end
              svf_pkg::OP_NEXT:    state <= S_SCAN;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          // One carry per cycle, or one cell handed on to the address steps
          if (finished || empty_grid) begin
            finished <= 1'b1;
            state    <= S_OUT;
          end else if (CMPW'(cur_z) >= ez) begin
            cur_z <= '0;
            cur_y <= cur_y + 1'b1;
          end else if (CMPW'(cur_y) >= ey) begin
            cur_y <= '0;
            cur_x <= cur_x + 1'b1;
          end else if (CMPW'(cur_x) >= ex) begin
            finished <= 1'b1;
          end else begin
            cur_z <= cur_z + 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADDR;
        end
        S_ADDR: begin
          state <= S_CHK;
        end
        S_CHK: begin
          nb    <= svf_pkg::NB_YP;
          state <= (rd_data == '0) ? S_SCAN : S_NB;
        end
        S_NB: begin
          state <= nb_out ? S_OUT : S_NBW;
        end
        S_NBW: begin
          if (rd_data == '0) begin
            state <= S_OUT;
          end else if (nb == svf_pkg::NB_ZP) begin
            state <= S_SCAN;
          end else begin
            nb    <= svf_pkg::nb_dir_t'(nb + 3'd1);
            state <= S_NB;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (state == S_SCAN) begin
      cx        <= cur_x;
      cy        <= cur_y;
      cz        <= cur_z;
      res_found <= 1'b0;
      res_index <= '0;
    end
    if (state == S_MUL) begin
      prod_y <= IW'(IW'(cy) * IW'(geom.sx));
      prod_z <= IW'(IW'(cz) * IW'(geom.plane));
    end
    if (state == S_ADDR) begin
      center <= center_sum;
    end
    if ((state == S_NB && nb_out) || (state == S_NBW && rd_data == '0)) begin
      res_found <= 1'b1;
      res_index <= center;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.found_index <= res_index;
      out_data.found       <= res_found;
    end
  end

  // No command leaves the queue during a sweep
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !pop)
    else $error("queue popped during store sweep");

  // A result appears only from the output state
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result without sequencer output step");

  // Exhausted scan reports index zero
  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.found_index == '0)
    else $error("exhausted result with nonzero index");

  // A found voxel never comes from a finished scan
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && out_data.found |-> !finished)
    else $error("voxel reported after scan end");

endmodule

`default_nettype wire

[hw/rtl/surface_voxel_finder_unit.sv]
`default_nettype none

// Surface voxel finder. Holds a 32768-cell store of 8-bit materials forming a
// size_x * size_y * size_z grid (x fastest), and answers "next visible voxel"
// requests by scanning x outer, y middle, z inner; a cell is visible when it is
// nonzero and one of its six neighbors is empty or off the grid. After reset
// the store is swept to zero with in_ch.ready low; a clear command runs the
// same sweep without holding off input. A restart takes effect at the edge
// that pops it from the command queue; a write lands in the store in the cycle
// after that pop. A next request leaves the queue, takes a scan step per
// cursor carry, passes each cell through the scan, multiply, address and check
// states, and for a filled cell tries its neighbors in turn, reading on-grid
// ones from the store, until one is open, then loads the output register; its
// latency depends on the data: the single read port fetches one cell, center
// or neighbor, at a time. Command beats are queued, so the input side keeps
// accepting up to three commands while a result waits in the output register.
module surface_voxel_finder_unit #(
  parameter int MAX_AXIS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  svf_in_if.sink                           in_ch,
  svf_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [svf_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int SW = svf_pkg::SIZE_W;

  logic [SW-1:0] size_x, size_y, size_z;
  svf_pkg::geom_t        geom;
  svf_pkg::back_status_t status;
  svf_pkg::cmd_t         push_cmd;
  svf_pkg::cmd_t         head;
  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_empty;
  logic [SW-1:0]         ex, ey, ez;
  logic [svf_pkg::PLANE_W-1:0] plane;
  logic [svf_pkg::VOL_W-1:0]   volume;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= '0;
      size_y <= '0;
      size_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        svf_pkg::REG_SIZE_X: size_x <= cfg_data;
        svf_pkg::REG_SIZE_Y: size_y <= cfg_data;
        svf_pkg::REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Extents saturate at MAX_AXIS
  assign ex = (int'(size_x) > MAX_AXIS) ? SW'(MAX_AXIS) : size_x;
  assign ey = (int'(size_y) > MAX_AXIS) ? SW'(MAX_AXIS) : size_y;
  assign ez = (int'(size_z) > MAX_AXIS) ? SW'(MAX_AXIS) : size_z;

  assign geom.sx     = ex;
  assign geom.sy     = ey;
  assign geom.sz     = ez;
  assign geom.plane  = plane;
  assign geom.volume = volume;

  // Plane and volume products, one multiply per register
  always_ff @(posedge clk) begin
    plane  <= svf_pkg::PLANE_W'(ex) * svf_pkg::PLANE_W'(ey);
    volume <= svf_pkg::VOL_W'(plane) * svf_pkg::VOL_W'(ez);
  end

  svf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .status   (status),
    .q_full   (q_full),
    .push_cmd (push_cmd),
    .push     (push)
  );

  svf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  svf_back #(
    .MAX_AXIS (MAX_AXIS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[bench/svf_surface_checker.sv]
module svf_surface_checker #(
  parameter int MAX_AXIS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  svf_in_if                               in_ch,
  svf_out_if                              out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [svf_pkg::SIZE_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              hits_pending
);
  import svf_pkg::*;

  // Shadow copy of the grid and the scan position
  logic [MAT_W-1:0] voxel_mem [STORE_CELLS];
  int               gx, gy, gz;
  int               cur_x, cur_y, cur_z;
  bit               scan_done;

  // Answers still owed by the block, oldest first
  out_beat_t        hit_queue[$];
  out_beat_t        due_hit;

  function automatic int axis_span(logic [SIZE_W-1:0] s);
    return (s > MAX_AXIS) ? MAX_AXIS : int'(s);
  endfunction

  function automatic logic [IDX_W-1:0] cell_addr(int x, int y, int z);
    int flat;
    flat = x + y * gx + z * gx * gy;
    return flat[IDX_W-1:0];
  endfunction

  // Off-grid neighbors count as open
  function automatic bit is_open(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= gx || y >= gy || z >= gz) return 1'b1;
    return voxel_mem[cell_addr(x, y, z)] == '0;
  endfunction

  // Walk x outer, y middle, z inner to the next filled cell with an open face
  function automatic out_beat_t next_surface_hit();
    int x, y, z;
    out_beat_t hit;
    hit = '0;
    while (1) begin
      if (scan_done || gx == 0 || gy == 0 || gz == 0) begin
        scan_done = 1'b1;
        return hit;
      end
      if (cur_z >= gz) begin
        cur_z = 0;
        cur_y++;
      end else if (cur_y >= gy) begin
        cur_y = 0;
        cur_x++;
      end else if (cur_x >= gx) begin
        scan_done = 1'b1;
      end else begin
        x = cur_x;
        y = cur_y;
        z = cur_z;
        cur_z++;
        if (voxel_mem[cell_addr(x, y, z)] != '0 &&
            (is_open(x, y + 1, z) || is_open(x, y - 1, z) ||
             is_open(x + 1, y, z) || is_open(x - 1, y, z) ||
             is_open(x, y, z - 1) || is_open(x, y, z + 1))) begin
          hit.found_index = cell_addr(x, y, z);
          hit.found       = 1'b1;
          return hit;
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] surface check: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_CELLS; i++) voxel_mem[i] = '0;
      gx = 0;
      gy = 0;
      gz = 0;
      cur_x = 0;
      cur_y = 0;
      cur_z = 0;
      scan_done = 1'b0;
      hit_queue.delete();
      fail_count = 0;
    end else begin
      // extent registers; unknown index is dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: gx = axis_span(cfg_data);
          REG_SIZE_Y: gy = axis_span(cfg_data);
          REG_SIZE_Z: gz = axis_span(cfg_data);
          default: ;
        endcase
      end

      // result beat against the oldest owed answer
      if (out_ch.valid && out_ch.ready) begin
        if (hit_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d found %0b",
                                    out_ch.data.found_index, out_ch.data.found));
        end else begin
          due_hit = hit_queue.pop_front();
          if (out_ch.data.found !== due_hit.found)
            report_mismatch($sformatf("found %0b, predicted %0b",
                                      out_ch.data.found, due_hit.found));
          if (out_ch.data.found_index !== due_hit.found_index)
            report_mismatch($sformatf("found_index %0d, predicted %0d",
                                      out_ch.data.found_index, due_hit.found_index));
        end
      end

      // command beat updates the shadow state
      if (in_ch.valid && in_ch.ready) begin
        case (op_t'(in_ch.data.opcode))
          OP_WRITE: begin
            if (int'(in_ch.data.cell_index) < gx * gy * gz)
              voxel_mem[in_ch.data.cell_index] = in_ch.data.material;
          end
          OP_CLEAR: begin
            for (int i = 0; i < STORE_CELLS; i++) voxel_mem[i] = '0;
          end
          OP_RESTART: begin
            cur_x = 0;
            cur_y = 0;
            cur_z = 0;
            scan_done = 1'b0;
          end
          OP_NEXT: hit_queue = {hit_queue, next_surface_hit()};
          default: ;
        endcase
      end
    end
    hits_pending = hit_queue.size();
  end

endmodule

[bench/tb_surface_voxel_finder_unit.sv]
module tb_surface_voxel_finder_unit;
  import svf_pkg::*;

  localparam int MAX_AXIS    = 32;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_BEATS = 62;
  localparam int SETTLE      = 40;
  localparam int MAX_CLEARS  = 5;
  localparam int TIMEOUT     = 8_000_000;
  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  int                fail_count;
  int                hits_pending;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                grid_cells;
  int                clears_left;

  svf_in_if  in_ch ();
  svf_out_if out_ch ();

  surface_voxel_finder_unit #(
    .MAX_AXIS(MAX_AXIS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  svf_surface_checker #(
    .MAX_AXIS(MAX_AXIS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .hits_pending(hits_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int axis_span(logic [SIZE_W-1:0] s);
    return (s > MAX_AXIS) ? MAX_AXIS : int'(s);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [SIZE_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_geometry(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                              logic [SIZE_W-1:0] sz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    grid_cells = axis_span(sx) * axis_span(sy) * axis_span(sz);
  endtask

  // One command beat; entered and left at a falling edge
  task automatic send_beat(op_t op, logic [IDX_W-1:0] idx, logic [MAT_W-1:0] mat);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid           = 1'b1;
    in_ch.data.opcode     = op;
    in_ch.data.cell_index = idx;
    in_ch.data.material   = mat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every owed answer is back, then let the block settle
  task automatic drain(int settle);
    in_ch.valid = 1'b0;
    while (hits_pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  initial begin
    logic [SIZE_W-1:0] sx, sy, sz;
    logic [IDX_W-1:0]  idx;
    logic [MAT_W-1:0]  mat;
    int                roll;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    grid_cells     = 0;
    clears_left    = MAX_CLEARS;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // zero extents: write dropped, scan exhausted at once
    send_beat(OP_WRITE, '1, '1);
    send_beat(OP_NEXT, '0, '0);
    drain(SETTLE);
    write_reg(REG_UNUSED, '1);

    // full 32-cube: both corner cells and one beside a corner, restart after exhaustion
    set_geometry(6'd32, 6'd32, 6'd32);
    send_beat(OP_RESTART, '0, '0);
    send_beat(OP_WRITE, '1, 8'hFF);
    send_beat(OP_WRITE, 15'd0, 8'h01);
    send_beat(OP_WRITE, 15'd1, 8'h80);
    send_beat(OP_NEXT, '0, '0);
    send_beat(OP_RESTART, '0, '0);
    send_beat(OP_NEXT, '0, '0);
    drain(SETTLE);

    // 3-cube with a buried center, then exhaust and stay exhausted
    set_geometry(6'd3, 6'd3, 6'd3);
    send_beat(OP_CLEAR, '0, '0);
    clears_left--;
    send_beat(OP_WRITE, 15'd13, 8'h5A);
    send_beat(OP_WRITE, 15'd12, 8'h11);
    send_beat(OP_WRITE, 15'd14, 8'h22);
    send_beat(OP_WRITE, 15'd10, 8'h33);
    send_beat(OP_WRITE, 15'd16, 8'h44);
    send_beat(OP_WRITE, 15'd4, 8'h55);
    send_beat(OP_WRITE, 15'd22, 8'h66);
    repeat (8) send_beat(OP_NEXT, '0, '0);
    drain(SETTLE);

    // random phases; the cursor carries over each extent change
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (p)
        0: begin sx = 6'd4;  sy = 6'd4;  sz = 6'd4;  end
        1: begin sx = 6'd2;  sy = 6'd3;  sz = 6'd5;  end
        2: begin sx = 6'd63; sy = 6'd1;  sz = 6'd2;  end
        3: begin sx = 6'd1;  sy = 6'd1;  sz = 6'd1;  end
        4: begin sx = 6'd0;  sy = 6'd3;  sz = 6'd3;  end
        5: begin sx = 6'd3;  sy = 6'd5;  sz = 6'd2;  end
        6: begin sx = 6'd1;  sy = 6'd32; sz = 6'd1;  end
        7: begin sx = 6'd4;  sy = 6'd2;  sz = 6'd4;  end
        8: begin sx = 6'd2;  sy = 6'd2;  sz = 6'd40; end
        default: begin sx = 6'd5; sy = 6'd5; sz = 6'd2; end
      endcase
      set_geometry(sx, sy, sz);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2 && p % 3 == 1) drain(0);
        roll = int'($urandom_range(0, 99));
        // unused fields carry noise
        idx  = IDX_W'($urandom_range(0, STORE_CELLS - 1));
        mat  = MAT_W'($urandom_range(0, 255));
        if (roll < 50) begin
          if (grid_cells > 0 && $urandom_range(0, 4) != 0)
            idx = IDX_W'($urandom_range(0, grid_cells - 1));
          if ($urandom_range(0, 6) == 0) mat = '0;
          send_beat(OP_WRITE, idx, mat);
        end else if (roll < 85) begin
          send_beat(OP_NEXT, idx, mat);
        end else if (roll < 98 || clears_left == 0) begin
          send_beat(OP_RESTART, idx, mat);
        end else begin
          clears_left--;
          send_beat(OP_CLEAR, idx, mat);
        end
      end

      // a closing request proves every earlier command has retired
      send_beat(OP_NEXT, '0, '0);
      drain(SETTLE);
    end

    if (fail_count == 0 && hits_pending == 0) begin
      $display("surface_voxel_finder_unit verification clean");
    end else begin
      $display("surface_voxel_finder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("surface_voxel_finder_unit verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/svf_pkg.sv
hw/rtl/svf_in_if.sv
hw/rtl/svf_out_if.sv
hw/rtl/svf_front.sv
hw/rtl/svf_queue.sv
hw/rtl/svf_back.sv
hw/rtl/surface_voxel_finder_unit.sv
bench/svf_surface_checker.sv
bench/tb_surface_voxel_finder_unit.sv
